// ----- src/ppf_pkg.sv -----
// Shared constants, types and arithmetic helpers of the point pair feature unit.
package ppf_pkg;

  localparam int MAX_NODES_DEF = 4096;

  localparam logic OP_NODE = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam int CNT_W   = 13;
  localparam int NIDX_W  = 12;
  localparam int IDX_W   = 16;
  localparam int DIST_W  = 21;
  localparam int ANG_W   = 16;
  localparam int CR_W    = 39;  // cross components and dot products
  localparam int RED_W   = 30;  // reduced magnitudes

  localparam int SQ_N    = 31;  // cross norm root digits
  localparam int DSQ_N   = 21;  // distance root digits
  localparam int DIV1_DW = 56;
  localparam int DIV1_VW = 31;
  localparam int DIV1_QW = 25;
  localparam int DIV2_DW = 49;
  localparam int DIV2_VW = 26;
  localparam int DIV2_QW = 23;
  localparam int POLY_LAT = 10;
  localparam int ATAN_LAT = 1 + DIV2_QW + 1 + POLY_LAT;
  localparam int ANG_LAT  = 4 + SQ_N + 1 + DIV1_QW + ATAN_LAT + 2;

  localparam logic [25:0] ONE24    = 26'd16777216;
  localparam logic [24:0] TAN_PI8  = 25'd6949350;
  localparam logic [23:0] PI4_24   = 24'd13176795;
  localparam logic signed [27:0] PI2_24 = 28'sd26353589;
  localparam logic signed [27:0] PI_24  = 28'sd52707179;
  localparam logic [23:0] K9_24    = 24'd1351194;
  localparam logic signed [25:0] K7_24 = 26'sd2328289;
  localparam logic signed [25:0] K5_24 = 26'sd3351704;
  localparam logic signed [25:0] K3_24 = 26'sd5592341;
  localparam logic [15:0] ANGLE_MAX = 16'd51472;

  typedef struct packed {
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
    logic signed [19:0] pz;
    logic signed [19:0] py;
    logic signed [19:0] px;
  } node_t;

  // Q.24 product magnitude rounded half up
  function automatic logic [23:0] qround(input logic [47:0] m);
    logic [47:0] s;
    s = m + 48'd8388608;
    return s[47:24];
  endfunction

  function automatic logic [25:0] abs26(input logic signed [25:0] v);
    return v[25] ? 26'(-v) : 26'(v);
  endfunction

  function automatic logic signed [25:0] sgn(input logic n, input logic [23:0] r);
    logic signed [25:0] v;
    v = $signed({2'b00, r});
    return n ? -v : v;
  endfunction

endpackage

// ----- src/ppf_delay.sv -----
// Enabled shift-register delay line.
module ppf_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= din;
      for (int i = 1; i < D; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign dout = pipe[D-1];

endmodule

// ----- src/ppf_sqrt.sv -----
// Pipelined floor square root, one result digit per stage.
module ppf_sqrt #(
  parameter int N = 21
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] rad,
  output logic [N-1:0]   root
);

  localparam int RW = N + 1;

  logic [RW-1:0]  rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] rad_q  [N];
  logic [RW-1:0]  rem_i  [N];
  logic [N-1:0]   root_i [N];
  logic [2*N-1:0] rad_i  [N];
  logic [RW-1:0]  rem_n  [N];
  logic [N-1:0]   root_n [N];
  logic [2*N-1:0] rad_n  [N];
  logic [RW+1:0]  cur    [N];
  logic [RW+1:0]  trial  [N];
  logic           fit    [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_i[k]  = '0;
        root_i[k] = '0;
        rad_i[k]  = rad;
      end else begin
        rem_i[k]  = rem_q[k-1];
        root_i[k] = root_q[k-1];
        rad_i[k]  = rad_q[k-1];
      end
      cur[k]    = {rem_i[k], rad_i[k][2*N-1 -: 2]};
      trial[k]  = {1'b0, root_i[k], 2'b01};
      fit[k]    = cur[k] >= trial[k];
      rem_n[k]  = fit[k] ? RW'(cur[k] - trial[k]) : RW'(cur[k]);
      root_n[k] = {root_i[k][N-2:0], fit[k]};
      rad_n[k]  = rad_i[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= rem_n[k];
        root_q[k] <= root_n[k];
        rad_q[k]  <= rad_n[k];
      end
    end
  end

  assign root = root_q[N-1];

endmodule

// ----- src/ppf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; quotient must fit QW bits.
module ppf_div #(
  parameter int DW = 56,
  parameter int VW = 31,
  parameter int QW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [QW-1:0] quo
);

  logic [VW-1:0] rem_q [QW];
  logic [VW-1:0] den_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [VW-1:0] rem_i [QW];
  logic [VW-1:0] den_i [QW];
  logic [QW-1:0] lo_i  [QW];
  logic [VW-1:0] rem_n [QW];
  logic [QW-1:0] lo_n  [QW];
  logic [VW:0]   cur   [QW];
  logic          fit   [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_i[k] = VW'(dividend[DW-1:QW]);
        den_i[k] = divisor;
        lo_i[k]  = dividend[QW-1:0];
      end else begin
        rem_i[k] = rem_q[k-1];
        den_i[k] = den_q[k-1];
        lo_i[k]  = lo_q[k-1];
      end
      cur[k]   = {rem_i[k], lo_i[k][QW-1]};
      fit[k]   = cur[k] >= {1'b0, den_i[k]};
      rem_n[k] = fit[k] ? VW'(cur[k] - {1'b0, den_i[k]}) : VW'(cur[k]);
      lo_n[k]  = {lo_i[k][QW-2:0], fit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_n[k];
        den_q[k] <= den_i[k];
        lo_q[k]  <= lo_n[k];
      end
    end
  end

  assign quo = lo_q[QW-1];

endmodule

// ----- src/ppf_atan.sv -----
// Pipelined Q.24 arctangent: octant reduction divide, then degree-9 odd polynomial.
module ppf_atan (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [24:0]        t,
  output logic signed [26:0] acute
);

  localparam int PL = ppf_pkg::POLY_LAT;

  logic [ppf_pkg::DIV2_DW-1:0] num_c1;
  logic [ppf_pkg::DIV2_VW-1:0] den_c1;
  logic [24:0]                 t_c1;
  logic                        gt_c1;
  logic [ppf_pkg::DIV2_QW-1:0] q;
  logic [24:0]                 t_d;
  logic                        gt_d;
  logic [25:0]                 den_w;

  assign den_w = 26'(t) + ppf_pkg::ONE24;

  // reduce arguments above tan(pi/8) to (1-t)/(1+t)
  always_ff @(posedge clk) begin
    if (en) begin
      gt_c1  <= t > ppf_pkg::TAN_PI8;
      t_c1   <= t;
      den_c1 <= den_w;
      num_c1 <= {25'(ppf_pkg::ONE24) - t, 24'b0} + 49'(den_w >> 1);
    end
  end

  ppf_div #(
    .DW(ppf_pkg::DIV2_DW), .VW(ppf_pkg::DIV2_VW), .QW(ppf_pkg::DIV2_QW)
  ) u_div (
    .clk(clk), .en(en), .dividend(num_c1), .divisor(den_c1), .quo(q)
  );

  ppf_delay #(.W(26), .D(ppf_pkg::DIV2_QW)) u_dly (
    .clk(clk), .rst(rst), .en(en), .din({gt_c1, t_c1}), .dout({gt_d, t_d})
  );

  logic signed [25:0] x_s    [PL];
  logic [23:0]        base_s [PL];
  logic [47:0]        mxx, mk, mxs, m5, m7, m9;
  logic [23:0]        sq2, sq3, sq4, sq5, sq6;
  logic signed [25:0] p1v, p2v, p3v, xs4, xs5, xs6, xs7, xs8;
  logic               n5, n7, n9;

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0]    <= gt_d ? -$signed({3'b000, q}) : $signed({1'b0, t_d});
      base_s[0] <= gt_d ? ppf_pkg::PI4_24 : 24'd0;
      for (int i = 1; i < PL; i++) begin
        x_s[i]    <= x_s[i-1];
        base_s[i] <= base_s[i-1];
      end
      mxx <= 48'(ppf_pkg::abs26(x_s[0])) * 48'(ppf_pkg::abs26(x_s[0]));
      sq2 <= ppf_pkg::qround(mxx);
      mk  <= 48'(ppf_pkg::K9_24) * 48'(sq2);
      mxs <= 48'(ppf_pkg::abs26(x_s[2])) * 48'(sq2);
      sq3 <= sq2;
      p1v <= $signed({2'b00, ppf_pkg::qround(mk)}) - ppf_pkg::K7_24;
      xs4 <= ppf_pkg::sgn(x_s[3][25], ppf_pkg::qround(mxs));
      sq4 <= sq3;
      m5  <= 48'(ppf_pkg::abs26(p1v)) * 48'(sq4);
      n5  <= p1v[25];
      sq5 <= sq4;
      xs5 <= xs4;
      p2v <= ppf_pkg::sgn(n5, ppf_pkg::qround(m5)) + ppf_pkg::K5_24;
      sq6 <= sq5;
      xs6 <= xs5;
      m7  <= 48'(ppf_pkg::abs26(p2v)) * 48'(sq6);
      n7  <= p2v[25];
      xs7 <= xs6;
      p3v <= ppf_pkg::sgn(n7, ppf_pkg::qround(m7)) - ppf_pkg::K3_24;
      xs8 <= xs7;
      m9  <= 48'(ppf_pkg::abs26(xs8)) * 48'(ppf_pkg::abs26(p3v));
      n9  <= xs8[25] ^ p3v[25];
      acute <= $signed({3'b000, base_s[PL-1]}) + 27'(x_s[PL-1])
             + 27'(ppf_pkg::sgn(n9, ppf_pkg::qround(m9)));
    end
  end

endmodule

// ----- src/ppf_angle.sv -----
// Pipelined angle of one vector pair from its cross product and dot product.
module ppf_angle (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic signed [ppf_pkg::CR_W-1:0]  cx,
  input  logic signed [ppf_pkg::CR_W-1:0]  cy,
  input  logic signed [ppf_pkg::CR_W-1:0]  cz,
  input  logic signed [ppf_pkg::CR_W-1:0]  dot,
  output logic [ppf_pkg::ANG_W-1:0]        angle
);

  localparam int CW = ppf_pkg::CR_W;
  localparam int RW = ppf_pkg::RED_W;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  logic [CW-1:0]   mx1, my1, mz1, md1;
  logic            negd1, negd2, negd3, negd4;
  logic [CW-1:0]   orm;
  logic [3:0]      sh;
  logic [RW-1:0]   mx2, my2, mz2, md2, md3, md4;
  logic [2*RW-1:0] sx3, sy3, sz3;
  logic [2*RW+1:0] sum4;
  logic [ppf_pkg::SQ_N-1:0] cr;
  logic [RW-1:0]   md_d;
  logic            negd_d;

  // drop the least common number of low bits that keeps all four under 2^30
  always_comb begin
    orm = mx1 | my1 | mz1 | md1;
    sh  = 4'd9;
    for (int s = 9; s >= 0; s--) begin
      if ((orm >> (RW + s)) == '0) sh = 4'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1   <= mag(cx);
      my1   <= mag(cy);
      mz1   <= mag(cz);
      md1   <= mag(dot);
      negd1 <= dot[CW-1];
      mx2   <= RW'(mx1 >> sh);
      my2   <= RW'(my1 >> sh);
      mz2   <= RW'(mz1 >> sh);
      md2   <= RW'(md1 >> sh);
      negd2 <= negd1;
      sx3   <= mx2 * mx2;
      sy3   <= my2 * my2;
      sz3   <= mz2 * mz2;
      md3   <= md2;
      negd3 <= negd2;
      sum4  <= (2*RW+2)'(sx3) + (2*RW+2)'(sy3) + (2*RW+2)'(sz3);
      md4   <= md3;
      negd4 <= negd3;
    end
  end

  ppf_sqrt #(.N(ppf_pkg::SQ_N)) u_root (
    .clk(clk), .en(en), .rad(sum4), .root(cr)
  );

  ppf_delay #(.W(RW + 1), .D(ppf_pkg::SQ_N)) u_dly_md (
    .clk(clk), .rst(rst), .en(en), .din({negd4, md4}), .dout({negd_d, md_d})
  );

  // ratio of the smaller over the larger, rounded to nearest in Q.24
  logic [ppf_pkg::DIV1_DW-1:0] num_b;
  logic [ppf_pkg::DIV1_VW-1:0] den_b;
  logic [2:0]                  flags_b, flags_d;
  logic                        le_w;
  logic [ppf_pkg::DIV1_QW-1:0] ratio;
  logic signed [26:0]          acute;

  assign le_w = cr <= ppf_pkg::DIV1_VW'(md_d);

  always_ff @(posedge clk) begin
    if (en) begin
      flags_b <= {le_w, cr == '0, negd_d};
      if (le_w) begin
        num_b <= {cr, 24'b0} + ppf_pkg::DIV1_DW'(md_d >> 1);
        den_b <= ppf_pkg::DIV1_VW'(md_d);
      end else begin
        num_b <= {ppf_pkg::DIV1_VW'(md_d), 24'b0} + ppf_pkg::DIV1_DW'(cr >> 1);
        den_b <= cr;
      end
    end
  end

  ppf_div #(
    .DW(ppf_pkg::DIV1_DW), .VW(ppf_pkg::DIV1_VW), .QW(ppf_pkg::DIV1_QW)
  ) u_div (
    .clk(clk), .en(en), .dividend(num_b), .divisor(den_b), .quo(ratio)
  );

  ppf_atan u_atan (
    .clk(clk), .rst(rst), .en(en), .t(ratio), .acute(acute)
  );

  ppf_delay #(.W(3), .D(ppf_pkg::DIV1_QW + ppf_pkg::ATAN_LAT)) u_dly_flags (
    .clk(clk), .rst(rst), .en(en), .din(flags_b), .dout(flags_d)
  );

  logic signed [27:0] a2, rs;
  logic [26:0]        r1;
  logic               crz1, negd5;
  logic [27:0]        rnd;
  logic [17:0]        rq;

  always_comb begin
    a2  = flags_d[2] ? 28'(acute) : ppf_pkg::PI2_24 - 28'(acute);
    rs  = flags_d[0] ? ppf_pkg::PI_24 - a2 : a2;
    rnd = 28'(r1) + 28'd512;
    rq  = rnd[27:10];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1    <= rs[27] ? 27'd0 : rs[26:0];
      crz1  <= flags_d[1];
      negd5 <= flags_d[0];
      if (crz1) begin
        angle <= negd5 ? ppf_pkg::ANGLE_MAX : '0;
      end else if (rq > 18'(ppf_pkg::ANGLE_MAX)) begin
        angle <= ppf_pkg::ANGLE_MAX;
      end else begin
        angle <= rq[15:0];
      end
    end
  end

endmodule

// ----- src/point_pair_feature_unit_core.sv -----
// Point pair feature unit top level: node table, geometry front end, feature pipelines.
//
// Usage: items arrive on the s_ stream. tuser = 0 writes one node (position and
// unit normal) into the node table; tuser = 1 is an edge that names a source and
// a target node and produces one result on the m_ stream: the distance between
// the nodes and three angles (target normal vs. offset, source normal vs.
// offset, target normal vs. source normal). Node writes produce no result.
// An edge index below zero, at or above node_count, or beyond the table gives
// an all-zero result with tuser set.
// Configuration: node_count is written through cfg_valid/cfg_data, always ready;
// write it only while no edge is in flight.
// Throughput: one item per cycle while the output is not stalled. The depth from an edge
// transfer to its result on m_tvalid is set by the 31-step norm root and the
// 25-step and 23-step divider chains of the angle pipelines.
// A node write is visible to an edge accepted in the next cycle.
// Reset clears node_count and all valid bits; table contents stay undefined.
// Stall: while a result waits on m_tready the pipeline keeps advancing until the
// next result reaches the last pipeline stage; only then do the pipeline and s_tready
// hold, so no item is lost or repeated.
module point_pair_feature_unit_core #(
  parameter int MAX_NODES = ppf_pkg::MAX_NODES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // node_index[11:0] pos_x[31:12] pos_y[51:32] pos_z[71:52] nrm_x[87:72]
  // nrm_y[103:88] nrm_z[119:104] source_index[135:120] target_index[151:136]
  input  logic [151:0] s_tdata,
  // opcode[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // distance[20:0] angle_target_normal[36:21] angle_source_normal[52:37]
  // angle_between_normals[68:53], zero fill [71:69]
  output logic [71:0]  m_tdata,
  // index_invalid[0]
  output logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [ppf_pkg::CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_NODES);

  // Node count register
  logic [ppf_pkg::CNT_W-1:0] node_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  // Flow control: advance whenever the output stage is free or the last
  // pipeline stage carries no result.
  logic en, out_free, last_valid, accept;

  assign out_free = !m_tvalid || m_tready;
  assign en       = out_free || !last_valid;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // Input unpacking
  logic [ppf_pkg::NIDX_W-1:0] node_index;
  logic [ppf_pkg::IDX_W-1:0]  src_idx, tgt_idx;
  ppf_pkg::node_t             wr_node;

  assign node_index = s_tdata[11:0];
  assign wr_node    = {s_tdata[119:104], s_tdata[103:88], s_tdata[87:72],
                       s_tdata[71:52], s_tdata[51:32], s_tdata[31:12]};
  assign src_idx    = s_tdata[135:120];
  assign tgt_idx    = s_tdata[151:136];

  logic src_bad, tgt_bad, wr_ok;

  assign src_bad = src_idx[15]
                || ({1'b0, src_idx[14:0]} >= {3'b000, node_count})
                || (32'(src_idx[14:0]) >= 32'(MAX_NODES));
  assign tgt_bad = tgt_idx[15]
                || ({1'b0, tgt_idx[14:0]} >= {3'b000, node_count})
                || (32'(tgt_idx[14:0]) >= 32'(MAX_NODES));
  assign wr_ok   = 32'(node_index) < 32'(MAX_NODES);

  // Node table: one write port, two registered read ports
  ppf_pkg::node_t node_mem [MAX_NODES];
  ppf_pkg::node_t ent_s, ent_t;

  always_ff @(posedge clk) begin
    if (accept && s_tuser[0] == ppf_pkg::OP_NODE && wr_ok) begin
      node_mem[AW'(node_index)] <= wr_node;
    end
    if (en) begin
      ent_s <= node_mem[AW'(src_idx[14:0])];
      ent_t <= node_mem[AW'(tgt_idx[14:0])];
    end
  end

  // Valid and invalid-index flags through the front end
  logic v_r, v_d, v_p, v_c;
  logic inv_r, inv_d, inv_p, inv_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
      v_d <= 1'b0;
      v_p <= 1'b0;
      v_c <= 1'b0;
    end else if (en) begin
      v_r <= accept && s_tuser[0] == ppf_pkg::OP_EDGE;
      v_d <= v_r;
      v_p <= v_d;
      v_c <= v_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r <= src_bad || tgt_bad;
      inv_d <= inv_r;
      inv_p <= inv_d;
      inv_c <= inv_p;
    end
  end

  // Offset and normals
  logic signed [20:0] dv [3];
  logic signed [20:0] nt [3];
  logic signed [20:0] ns [3];

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= 21'(ent_s.px) - 21'(ent_t.px);
      dv[1] <= 21'(ent_s.py) - 21'(ent_t.py);
      dv[2] <= 21'(ent_s.pz) - 21'(ent_t.pz);
      nt[0] <= 21'(ent_t.nx);
      nt[1] <= 21'(ent_t.ny);
      nt[2] <= 21'(ent_t.nz);
      ns[0] <= 21'(ent_s.nx);
      ns[1] <= 21'(ent_s.ny);
      ns[2] <= 21'(ent_s.nz);
    end
  end

  // All pairwise component products; pair 0 = (nt, d), 1 = (ns, d), 2 = (nt, ns)
  logic signed [36:0] prod [3][3][3];
  logic [41:0]        dsq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[0][i][j] <= 37'(nt[i]) * 37'(dv[j]);
          prod[1][i][j] <= 37'(ns[i]) * 37'(dv[j]);
          prod[2][i][j] <= 37'(nt[i]) * 37'(ns[j]);
        end
        dsq[i] <= 42'(42'(dv[i]) * 42'(dv[i]));
      end
    end
  end

  // Cross components and dot products
  logic signed [ppf_pkg::CR_W-1:0] crs [3][3];
  logic signed [ppf_pkg::CR_W-1:0] dtp [3];
  logic [41:0]                     dsum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        crs[p][0] <= ppf_pkg::CR_W'(prod[p][1][2]) - ppf_pkg::CR_W'(prod[p][2][1]);
        crs[p][1] <= ppf_pkg::CR_W'(prod[p][2][0]) - ppf_pkg::CR_W'(prod[p][0][2]);
        crs[p][2] <= ppf_pkg::CR_W'(prod[p][0][1]) - ppf_pkg::CR_W'(prod[p][1][0]);
        dtp[p]    <= ppf_pkg::CR_W'(prod[p][0][0]) + ppf_pkg::CR_W'(prod[p][1][1])
                   + ppf_pkg::CR_W'(prod[p][2][2]);
      end
      dsum <= dsq[0] + dsq[1] + dsq[2];
    end
  end

  // Feature pipelines
  logic [ppf_pkg::ANG_W-1:0] ang [3];

  for (genvar p = 0; p < 3; p++) begin : g_pair
    ppf_angle u_angle (
      .clk(clk), .rst(rst), .en(en),
      .cx(crs[p][0]), .cy(crs[p][1]), .cz(crs[p][2]), .dot(dtp[p]),
      .angle(ang[p])
    );
  end

  logic [ppf_pkg::DIST_W-1:0] dist_r, dist_d;

  ppf_sqrt #(.N(ppf_pkg::DSQ_N)) u_dist (
    .clk(clk), .en(en), .rad(dsum), .root(dist_r)
  );

  ppf_delay #(.W(ppf_pkg::DIST_W), .D(ppf_pkg::ANG_LAT - ppf_pkg::DSQ_N)) u_dly_dist (
    .clk(clk), .rst(rst), .en(en), .din(dist_r), .dout(dist_d)
  );

  logic inv_l;

  ppf_delay #(.W(2), .D(ppf_pkg::ANG_LAT)) u_dly_flags (
    .clk(clk), .rst(rst), .en(en), .din({v_c, inv_c}), .dout({last_valid, inv_l})
  );

  // Output register; zero the payload for a bad index
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tuser[0] <= inv_l;
      if (inv_l) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {3'b000, ang[2], ang[1], ang[0], dist_d};
      end
    end
  end

  // Checks
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input held without a stalled result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("invalid-index result carries data");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[36:21] <= ppf_pkg::ANGLE_MAX
                  && m_tdata[52:37] <= ppf_pkg::ANGLE_MAX
                  && m_tdata[68:53] <= ppf_pkg::ANGLE_MAX))
    else $error("angle above pi");

endmodule
